/* src/tcpc_pkg.sv */
// Shared types and constants for the task class promotion controller.
package tcpc_pkg;

  localparam int DL_W   = 16;
  localparam int IMP_W  = 4;
  localparam int ACT_W  = 3;
  localparam int TIDX_W = 5;
  localparam int PRIO_W = 13;
  localparam int CFG_W  = 8;

  localparam logic [ACT_W-1:0] ACT_NONE       = 3'd0;
  localparam logic [ACT_W-1:0] ACT_REGISTERED = 3'd1;
  localparam logic [ACT_W-1:0] ACT_FULL       = 3'd2;
  localparam logic [ACT_W-1:0] ACT_PROMOTED   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DEMOTED    = 3'd4;

  localparam logic [IMP_W-1:0] IMP_GUARANTEED  = 4'd5;
  localparam logic [IMP_W-1:0] IMP_BEST_EFFORT = 4'd0;

  localparam logic [CFG_W-1:0] PROMOTE_AFTER_RST = 8'd5;
  localparam logic [CFG_W-1:0] STREAK_MAX        = 8'hFF;

  // Reciprocals for dividing a 16-bit deadline by 20 and by 25. Both are
  // exact over the whole 16-bit range.
  localparam int RECIP_W     = 17;
  localparam int PROD_W      = DL_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP20 = 17'd52429;
  localparam int                 SHIFT20 = 20;
  localparam logic [RECIP_W-1:0] RECIP25 = 17'd83887;
  localparam int                 SHIFT25 = 21;

  localparam logic [PRIO_W-1:0] DMS_BASE  = 13'd80;
  localparam logic [PRIO_W-1:0] MUF_BASE  = 13'd60;
  localparam logic [PRIO_W-1:0] IMP_SCALE = 13'd10;

  typedef struct packed {
    logic latch;
    logic do_register;
    logic set_full;
    logic set_none;
    logic pop;
    logic tgt_latch;
    logic do_demote;
    logic streak_inc;
    logic streak_clr;
    logic scan_start;
    logic scan_run;
    logic do_promote;
    logic emit;
  } tcpc_cmd_t;

  typedef struct packed {
    logic req_type;
    logic gmiss;
    logic bmiss;
    logic table_full;
    logic stack_empty;
    logic tgt_bad;
    logic streak_hit;
    logic scan_done;
    logic found;
    logic out_free;
  } tcpc_status_t;

  // Priority in the importance bands: 10*importance + 60 - deadline/25.
  function automatic logic [PRIO_W-1:0] muf_prio(input logic [IMP_W-1:0] imp,
                                                 input logic [PRIO_W-1:0] q25);
    logic [PRIO_W-1:0] band;
    band = PRIO_W'({{(PRIO_W-IMP_W){1'b0}}, imp} * IMP_SCALE);
    return band + MUF_BASE - q25;
  endfunction

endpackage

/* src/tcpc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module tcpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* src/tcpc_ctrl.sv */
// Controller state machine: sequences register, demote and promote requests.
module tcpc_ctrl
  import tcpc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  tcpc_status_t status,
  output tcpc_cmd_t    cmd
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_DISPATCH = 7'b0000010,
    S_POP_WAIT = 7'b0000100,
    S_DEMOTE   = 7'b0001000,
    S_CHECK    = 7'b0010000,
    S_SCAN     = 7'b0100000,
    S_EMIT     = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (!status.req_type) begin
          if (status.table_full) begin
            cmd.set_full = 1'b1;
          end else begin
            cmd.do_register = 1'b1;
          end
          state_nxt = S_EMIT;
        end else if (status.gmiss) begin
          if (status.stack_empty) begin
            cmd.set_none = 1'b1;
            state_nxt    = S_EMIT;
          end else begin
            cmd.pop   = 1'b1;
            state_nxt = S_POP_WAIT;
          end
        end else if (status.bmiss) begin
          cmd.streak_inc = 1'b1;
          state_nxt      = S_CHECK;
        end else begin
          cmd.streak_clr = 1'b1;
          cmd.set_none   = 1'b1;
          state_nxt      = S_EMIT;
        end
      end
      S_POP_WAIT: begin
        // The popped index is on the stack read port in this cycle.
        if (status.tgt_bad) begin
          cmd.set_none = 1'b1;
          state_nxt    = S_EMIT;
        end else begin
          cmd.tgt_latch = 1'b1;
          state_nxt     = S_DEMOTE;
        end
      end
      S_DEMOTE: begin
        cmd.do_demote = 1'b1;
        state_nxt     = S_EMIT;
      end
      S_CHECK: begin
        if (status.streak_hit) begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end else begin
          cmd.set_none = 1'b1;
          state_nxt    = S_EMIT;
        end
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (status.scan_done) begin
          if (status.found) begin
            cmd.do_promote = 1'b1;
          end else begin
            cmd.set_none = 1'b1;
          end
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* src/tcpc_datapath.sv */
// Datapath: task table, promotion stack, streak counter, scan and priority math.
module tcpc_datapath
  import tcpc_pkg::*;
#(
  parameter int MAX_TASKS   = 32,
  parameter int STACK_DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  tcpc_cmd_t                cmd,
  output tcpc_status_t             status,
  input  logic                     in_req_type,
  input  logic [DL_W-1:0]          in_deadline,
  input  logic [IMP_W-1:0]         in_importance,
  input  logic                     in_guaranteed_miss,
  input  logic                     in_best_effort_miss,
  input  logic                     cfg_wr_en,
  input  logic [CFG_W-1:0]         cfg_wr_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [ACT_W-1:0]         out_action,
  output logic [TIDX_W-1:0]        out_task_index,
  output logic signed [PRIO_W-1:0] out_priority_res
);

  localparam int IDX_W  = $clog2(MAX_TASKS);
  localparam int CNT_W  = $clog2(MAX_TASKS + 1);
  localparam int SP_W   = $clog2(STACK_DEPTH);
  localparam int FILL_W = $clog2(STACK_DEPTH + 1);
  localparam int ENT_W  = DL_W + IMP_W;

  // Latched request.
  logic             req_r, gmiss_r, bmiss_r;
  logic [DL_W-1:0]  dl_r;
  logic [IMP_W-1:0] imp_r;

  logic [CFG_W-1:0]  promote_after_r;
  logic [CNT_W-1:0]  count_r;
  logic [FILL_W-1:0] fill_r;
  logic [CFG_W-1:0]  streak_r;

  logic [IDX_W-1:0] tgt_r;
  logic [CNT_W-1:0] scan_idx_r;
  logic             cmp_vld_r;
  logic [IDX_W-1:0] cmp_idx_r;
  logic [IDX_W-1:0] best_idx_r;
  logic [DL_W-1:0]  best_dl_r;
  logic             found_r;

  logic [ACT_W-1:0]  res_act_r;
  logic [TIDX_W-1:0] res_idx_r;
  logic [PRIO_W-1:0] res_prio_r;

  logic              out_valid_r;
  logic [ACT_W-1:0]  out_action_r;
  logic [TIDX_W-1:0] out_task_index_r;
  logic [PRIO_W-1:0] out_priority_res_r;

  // Task table: deadline in the upper bits, importance in the lower bits.
  logic             task_we;
  logic [IDX_W-1:0] task_waddr;
  logic [ENT_W-1:0] task_wdata;
  logic [IDX_W-1:0] task_raddr;
  logic [ENT_W-1:0] task_rdata;
  logic [DL_W-1:0]  rd_dl;
  logic [IMP_W-1:0] rd_imp;

  logic             stack_we;
  logic [SP_W-1:0]  stack_raddr;
  logic [IDX_W-1:0] stack_rdata;
  logic             stack_room;

  logic              scan_issue;
  logic [DL_W-1:0]   dl_sel;
  logic [PROD_W-1:0] prod20, prod25;
  logic [PRIO_W-1:0] q20, q25;

  assign rd_dl  = task_rdata[ENT_W-1:IMP_W];
  assign rd_imp = task_rdata[IMP_W-1:0];

  assign stack_room  = (fill_r < FILL_W'(STACK_DEPTH));
  assign stack_we    = cmd.do_promote && stack_room;
  assign stack_raddr = SP_W'(fill_r - 1'b1);
  assign scan_issue  = (scan_idx_r < count_r);

  assign task_we    = cmd.do_register || cmd.do_demote || cmd.do_promote;
  assign task_raddr = cmd.tgt_latch ? stack_rdata : scan_idx_r[IDX_W-1:0];

  always_comb begin
    priority if (cmd.do_demote) begin
      task_waddr = tgt_r;
      task_wdata = {rd_dl, IMP_BEST_EFFORT};
    end else if (cmd.do_promote) begin
      task_waddr = best_idx_r;
      task_wdata = {best_dl_r, IMP_GUARANTEED};
    end else begin
      task_waddr = count_r[IDX_W-1:0];
      task_wdata = {dl_r, imp_r};
    end
  end

  tcpc_ram #(
    .WIDTH(ENT_W),
    .DEPTH(MAX_TASKS)
  ) u_task_ram (
    .clk    (clk),
    .wr_en  (task_we),
    .wr_addr(task_waddr),
    .wr_data(task_wdata),
    .rd_addr(task_raddr),
    .rd_data(task_rdata)
  );

  tcpc_ram #(
    .WIDTH(IDX_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack_ram (
    .clk    (clk),
    .wr_en  (stack_we),
    .wr_addr(fill_r[SP_W-1:0]),
    .wr_data(best_idx_r),
    .rd_addr(stack_raddr),
    .rd_data(stack_rdata)
  );

  // Deadline quotients by reciprocal multiplication.
  always_comb begin
    priority if (cmd.do_demote) begin
      dl_sel = rd_dl;
    end else if (cmd.do_promote) begin
      dl_sel = best_dl_r;
    end else begin
      dl_sel = dl_r;
    end
  end

  assign prod20 = PROD_W'(dl_sel) * PROD_W'(RECIP20);
  assign prod25 = PROD_W'(dl_sel) * PROD_W'(RECIP25);
  assign q20    = PRIO_W'(prod20 >> SHIFT20);
  assign q25    = PRIO_W'(prod25 >> SHIFT25);

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r   <= in_req_type;
      dl_r    <= in_deadline;
      imp_r   <= in_importance;
      gmiss_r <= in_guaranteed_miss;
      bmiss_r <= in_best_effort_miss;
    end
    if (cmd.tgt_latch) begin
      tgt_r <= stack_rdata;
    end
    if (cmd.scan_start) begin
      scan_idx_r <= '0;
    end else if (cmd.scan_run && scan_issue) begin
      scan_idx_r <= scan_idx_r + 1'b1;
    end
    if (cmd.scan_run) begin
      cmp_idx_r <= scan_idx_r[IDX_W-1:0];
    end
    // The compare stage sees the entry that was addressed in the previous cycle.
    if (cmd.scan_run && cmp_vld_r && rd_imp == IMP_BEST_EFFORT &&
        (!found_r || rd_dl < best_dl_r)) begin
      best_idx_r <= cmp_idx_r;
      best_dl_r  <= rd_dl;
    end
    priority if (cmd.do_register) begin
      res_act_r  <= ACT_REGISTERED;
      res_idx_r  <= TIDX_W'(count_r);
      res_prio_r <= DMS_BASE - q20;
    end else if (cmd.do_demote) begin
      res_act_r  <= ACT_DEMOTED;
      res_idx_r  <= TIDX_W'(tgt_r);
      res_prio_r <= muf_prio(IMP_BEST_EFFORT, q25);
    end else if (cmd.do_promote) begin
      res_act_r  <= ACT_PROMOTED;
      res_idx_r  <= TIDX_W'(best_idx_r);
      res_prio_r <= muf_prio(IMP_GUARANTEED, q25);
    end else if (cmd.set_full) begin
      res_act_r  <= ACT_FULL;
      res_idx_r  <= '0;
      res_prio_r <= '0;
    end else if (cmd.set_none) begin
      res_act_r  <= ACT_NONE;
      res_idx_r  <= '0;
      res_prio_r <= '0;
    end
    if (cmd.emit) begin
      out_action_r       <= res_act_r;
      out_task_index_r   <= res_idx_r;
      out_priority_res_r <= res_prio_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      promote_after_r <= PROMOTE_AFTER_RST;
      count_r         <= '0;
      fill_r          <= '0;
      streak_r        <= '0;
      cmp_vld_r       <= 1'b0;
      found_r         <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        promote_after_r <= cfg_wr_data;
      end
      if (cmd.do_register) begin
        count_r <= count_r + 1'b1;
      end
      if (cmd.pop) begin
        fill_r <= fill_r - 1'b1;
      end else if (stack_we) begin
        fill_r <= fill_r + 1'b1;
      end
      if (cmd.streak_clr || cmd.do_promote) begin
        streak_r <= '0;
      end else if (cmd.streak_inc && streak_r != STREAK_MAX) begin
        streak_r <= streak_r + 1'b1;
      end
      if (cmd.scan_start) begin
        cmp_vld_r <= 1'b0;
        found_r   <= 1'b0;
      end else if (cmd.scan_run) begin
        cmp_vld_r <= scan_issue;
        if (cmp_vld_r && rd_imp == IMP_BEST_EFFORT) begin
          found_r <= 1'b1;
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign status.req_type    = req_r;
  assign status.gmiss       = gmiss_r;
  assign status.bmiss       = bmiss_r;
  assign status.table_full  = (count_r >= CNT_W'(MAX_TASKS));
  assign status.stack_empty = (fill_r == '0);
  assign status.tgt_bad     = (CNT_W'(stack_rdata) >= count_r);
  assign status.streak_hit  = (streak_r > promote_after_r);
  assign status.scan_done   = !scan_issue && !cmp_vld_r;
  assign status.found       = found_r;
  assign status.out_free    = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_action       = out_action_r;
  assign out_task_index   = out_task_index_r;
  assign out_priority_res = $signed(out_priority_res_r);

endmodule

/* src/task_class_promotion_controller.sv */
// Task class promotion controller: top level joining controller and datapath.
//
// Input channel (in_valid/in_ready) carries one request per beat: either a
// task registration (req_type 0) or a control-period report (req_type 1)
// with guaranteed and best-effort miss flags. Every request yields exactly
// one result beat on the output channel (out_valid/out_ready): action,
// task index and the task's new priority.
// Steps: after accept the request is dispatched. A registration, a table-full
// answer, a period without miss or a guaranteed miss on an empty stack is then
// loaded into the output register; a best-effort miss first passes the
// streak check, a guaranteed miss first reads the popped index, and unless
// it is stale the demotion writes the table. A promotion check walks the table
// once, one entry per cycle through the table RAM's read port. One request is
// in work at a time; in_ready comes back in the cycle after the load.
// The output register holds a finished result while the receiver stalls;
// the next request is still accepted, and its result waits until the
// output register is taken.
// cfg_wr_en/cfg_wr_data write the promotion threshold (reset value 5).
// Reset (rst_n low, synchronous) empties the task table and promotion
// stack, clears the miss streak and drops any pending output beat.
module task_class_promotion_controller
  import tcpc_pkg::*;
#(
  parameter int MAX_TASKS   = 32,
  parameter int STACK_DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_req_type,
  input  logic [DL_W-1:0]          in_deadline,
  input  logic [IMP_W-1:0]         in_importance,
  input  logic                     in_guaranteed_miss,
  input  logic                     in_best_effort_miss,
  input  logic                     cfg_wr_en,
  input  logic [CFG_W-1:0]         cfg_wr_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [ACT_W-1:0]         out_action,
  output logic [TIDX_W-1:0]        out_task_index,
  output logic signed [PRIO_W-1:0] out_priority_res
);

  tcpc_cmd_t    cmd;
  tcpc_status_t status;

  tcpc_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .status  (status),
    .cmd     (cmd)
  );

  tcpc_datapath #(
    .MAX_TASKS  (MAX_TASKS),
    .STACK_DEPTH(STACK_DEPTH)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_req_type        (in_req_type),
    .in_deadline        (in_deadline),
    .in_importance      (in_importance),
    .in_guaranteed_miss (in_guaranteed_miss),
    .in_best_effort_miss(in_best_effort_miss),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_action         (out_action),
    .out_task_index     (out_task_index),
    .out_priority_res   (out_priority_res)
  );

  // The controller only loads the output register when it can take a beat.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> status.out_free)
    else $error("result loaded while output register busy");

  // At most one result is produced per request step.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.do_register, cmd.set_full, cmd.set_none, cmd.do_demote,
              cmd.do_promote}))
    else $error("conflicting result commands");

  // One request in work at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request accepted while busy");

  // Beats without a task carry zero index and priority.
  a_no_task_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action == ACT_NONE || out_action == ACT_FULL)
      |-> out_task_index == '0 && out_priority_res == '0)
    else $error("nonzero payload on a beat without a task");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the task class promotion controller.
`timescale 1ns / 1ps

module tb_top
  import tcpc_pkg::*;
();

  localparam int TASK_SLOTS  = 32;
  localparam int STACK_SLOTS = 32;
  localparam int N_DIRECTED  = 16;
  localparam int STALL_LIMIT = 2000;
  localparam int CFG_QUIET   = 4;
  localparam int END_QUIET   = 60;

  typedef struct packed {
    logic              req_type;
    logic [DL_W-1:0]   deadline;
    logic [IMP_W-1:0]  importance;
    logic              gmiss;
    logic              bmiss;
  } request_t;

  typedef struct packed {
    logic [ACT_W-1:0]         action;
    logic [TIDX_W-1:0]        task_index;
    logic signed [PRIO_W-1:0] prio;
  } decision_t;

  typedef struct packed {
    request_t  rq;
    logic      typed;
    decision_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_req_type = 1'b0;
  logic [DL_W-1:0] in_deadline = '0;
  logic [IMP_W-1:0] in_importance = '0;
  logic in_guaranteed_miss = 1'b0;
  logic in_best_effort_miss = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ACT_W-1:0] out_action;
  logic [TIDX_W-1:0] out_task_index;
  logic signed [PRIO_W-1:0] out_priority_res;

  // Shadow copy of the controller state.
  logic [DL_W-1:0]   dl_of [TASK_SLOTS];
  logic [IMP_W-1:0]  imp_of [TASK_SLOTS];
  logic [TIDX_W-1:0] promo_stack [STACK_SLOTS];
  int n_tasks = 0;
  int promo_fill = 0;
  int streak = 0;
  logic [CFG_W-1:0] threshold = PROMOTE_AFTER_RST;

  decision_t pending_decisions[$];
  decision_t oldest;
  dir_row_t dir_tab [N_DIRECTED];
  int mismatches = 0;
  int idle_run = 0;
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;

  task_class_promotion_controller #(
    .MAX_TASKS(TASK_SLOTS),
    .STACK_DEPTH(STACK_SLOTS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_req_type(in_req_type),
    .in_deadline(in_deadline),
    .in_importance(in_importance),
    .in_guaranteed_miss(in_guaranteed_miss),
    .in_best_effort_miss(in_best_effort_miss),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_action(out_action),
    .out_task_index(out_task_index),
    .out_priority_res(out_priority_res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [PRIO_W-1:0] band_priority(logic [IMP_W-1:0] imp,
                                                             logic [DL_W-1:0] dl);
    return PRIO_W'(10 * int'(imp) + 60 - int'(dl) / 25);
  endfunction

  function automatic decision_t class_decision(request_t rq);
    decision_t d;
    logic [TIDX_W-1:0] t;
    int best;
    bit found;
    d = '0;
    d.action = ACT_NONE;
    if (!rq.req_type) begin
      if (n_tasks >= TASK_SLOTS) begin
        d.action = ACT_FULL;
      end else begin
        dl_of[n_tasks] = rq.deadline;
        imp_of[n_tasks] = rq.importance;
        d.action = ACT_REGISTERED;
        d.task_index = TIDX_W'(n_tasks);
        d.prio = PRIO_W'(80 - int'(rq.deadline) / 20);
        n_tasks++;
      end
    end else if (rq.gmiss) begin
      // A guaranteed miss wins over a best-effort miss and leaves the streak alone.
      if (promo_fill != 0) begin
        promo_fill--;
        t = promo_stack[promo_fill];
        if (int'(t) < n_tasks) begin
          imp_of[t] = IMP_BEST_EFFORT;
          d.action = ACT_DEMOTED;
          d.task_index = t;
          d.prio = band_priority(IMP_BEST_EFFORT, dl_of[t]);
        end
      end
    end else if (rq.bmiss) begin
      if (streak < int'(STREAK_MAX)) streak++;
      if (streak > int'(threshold)) begin
        found = 1'b0;
        best = 0;
        for (int i = 0; i < n_tasks; i++) begin
          if (imp_of[i] == IMP_BEST_EFFORT && (!found || dl_of[i] < dl_of[best])) begin
            found = 1'b1;
            best = i;
          end
        end
        // With no best-effort task the streak keeps its value.
        if (found) begin
          imp_of[best] = IMP_GUARANTEED;
          if (promo_fill < STACK_SLOTS) begin
            promo_stack[promo_fill] = TIDX_W'(best);
            promo_fill++;
          end
          streak = 0;
          d.action = ACT_PROMOTED;
          d.task_index = TIDX_W'(best);
          d.prio = band_priority(IMP_GUARANTEED, dl_of[best]);
        end
      end
    end else begin
      streak = 0;
    end
    return d;
  endfunction

  function automatic dir_row_t row(bit rt, int dl, int imp, bit g, bit b, bit typed,
                                   logic [ACT_W-1:0] act, int idx, int prio);
    dir_row_t r;
    r.rq.req_type = rt;
    r.rq.deadline = DL_W'(dl);
    r.rq.importance = IMP_W'(imp);
    r.rq.gmiss = g;
    r.rq.bmiss = b;
    r.typed = typed;
    r.want.action = act;
    r.want.task_index = TIDX_W'(idx);
    r.want.prio = PRIO_W'(prio);
    return r;
  endfunction

  // Called at a rising edge; returns at the edge where the beat is taken.
  task automatic send_request(request_t rq, bit typed, decision_t want);
    int gap;
    decision_t d;
    if ($urandom_range(0, 31) == 0) tx_steady = !tx_steady;
    gap = tx_steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= rq.req_type;
    in_deadline <= rq.deadline;
    in_importance <= rq.importance;
    in_guaranteed_miss <= rq.gmiss;
    in_best_effort_miss <= rq.bmiss;
    do @(posedge clk); while (!(in_valid && in_ready));
    d = class_decision(rq);
    pending_decisions.insert(pending_decisions.size(), typed ? want : d);
  endtask

  task automatic settle(input int tail);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_decisions.size() != 0);
    repeat (tail) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [CFG_W-1:0] value);
    settle(CFG_QUIET);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    threshold = value;
  endtask

  task automatic random_request(output request_t rq, input bit saturate);
    int pick;
    rq.req_type = 1'($urandom);
    rq.deadline = DL_W'($urandom);
    rq.importance = IMP_W'($urandom);
    rq.gmiss = 1'($urandom);
    rq.bmiss = 1'($urandom);
    if (saturate) begin
      rq.req_type = 1'b1;
      rq.bmiss = 1'b1;
      rq.gmiss = ($urandom_range(0, 19) == 0);
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < (n_tasks < TASK_SLOTS ? 45 : 8)) begin
        rq.req_type = 1'b0;
        // A small pool of deadlines makes ties in the promotion scan common.
        if (n_tasks < TASK_SLOTS && $urandom_range(0, 2) == 0)
          rq.deadline = DL_W'($urandom_range(0, 3) * 25);
        if ($urandom_range(0, 1) == 0) rq.importance = IMP_BEST_EFFORT;
      end else begin
        rq.req_type = 1'b1;
        pick = $urandom_range(0, 99);
        rq.gmiss = (pick < 30);
        rq.bmiss = (pick >= 20 && pick < 85);
      end
    end
  endtask

  task automatic run_random(input int count);
    request_t rq;
    for (int n = 0; n < count; n++) begin
      random_request(rq, 1'b0);
      if ($urandom_range(0, 49) == 0) settle(0);
      send_request(rq, 1'b0, '0);
    end
  endtask

  // Result side: random stalls, with stretches of steady readiness.
  initial begin
    int hold;
    do @(posedge clk); while (!rst_n);
    forever begin
      if ($urandom_range(0, 31) == 0) rx_steady = !rx_steady;
      hold = rx_steady ? 0 : $urandom_range(0, 11);
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_decisions.size() == 0) begin
        $display("%0t: unexpected beat: action %0d index %0d priority %0d", $time,
                 out_action, out_task_index, out_priority_res);
        mismatches++;
      end else begin
        oldest = pending_decisions.pop_front();
        if (out_action !== oldest.action) begin
          $display("%0t: action expected %0d actual %0d", $time, oldest.action, out_action);
          mismatches++;
        end
        if (out_task_index !== oldest.task_index) begin
          $display("%0t: task_index expected %0d actual %0d", $time, oldest.task_index,
                   out_task_index);
          mismatches++;
        end
        if (out_priority_res !== oldest.prio) begin
          $display("%0t: priority_res expected %0d actual %0d", $time, oldest.prio,
                   out_priority_res);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_run = 0;
    end else begin
      idle_run++;
      if (idle_run >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    request_t rq;
    int sat_seen;
    dir_tab[0] = row(1, 0, 0, 1, 0, 1, ACT_NONE, 0, 0);
    dir_tab[1] = row(1, 0, 0, 0, 0, 1, ACT_NONE, 0, 0);
    // Best-effort misses with no task at all: the streak passes the threshold
    // but there is nothing to promote.
    for (int i = 2; i < 8; i++)
      dir_tab[i] = row(1, (i == 2) ? 65535 : 0, (i == 2) ? 15 : 0, 0, 1, 1, ACT_NONE, 0, 0);
    dir_tab[8] = row(0, 0, 0, 0, 0, 1, ACT_REGISTERED, 0, 80);
    dir_tab[9] = row(0, 65535, 15, 0, 0, 1, ACT_REGISTERED, 1, -3196);
    dir_tab[10] = row(0, 40, 0, 0, 0, 0, ACT_NONE, 0, 0);
    dir_tab[11] = row(0, 40, 0, 1, 1, 0, ACT_NONE, 0, 0);
    dir_tab[12] = row(1, 0, 0, 0, 1, 1, ACT_PROMOTED, 0, 110);
    dir_tab[13] = row(1, 0, 0, 1, 1, 1, ACT_DEMOTED, 0, 60);
    dir_tab[14] = row(1, 0, 0, 1, 0, 1, ACT_NONE, 0, 0);
    dir_tab[15] = row(0, 65535, 0, 0, 0, 0, ACT_NONE, 0, 0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++)
      send_request(dir_tab[i].rq, dir_tab[i].typed, dir_tab[i].want);

    write_threshold('0);
    run_random(140);

    // Threshold at its top: the streak saturates and nothing is promoted.
    write_threshold(STREAK_MAX);
    sat_seen = 0;
    while (sat_seen < 10) begin
      random_request(rq, 1'b1);
      send_request(rq, 1'b0, '0);
      if (streak == int'(STREAK_MAX)) sat_seen++;
    end

    // A saturated streak still exceeds this one.
    write_threshold(CFG_W'(STREAK_MAX - 1'b1));
    run_random(100);

    write_threshold(CFG_W'($urandom_range(1, 10)));
    run_random(170);

    settle(END_QUIET);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
